// ===== rtl/assert_macros.svh =====
// Assertion helpers for the list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define DLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DLL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dll_pkg.sv =====
// ----------------------------------------------------------------------------
// dll_pkg
// Shared constants, codes and control types of the linked list engine.
// ----------------------------------------------------------------------------
package dll_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 7;
  localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [2:0] {
    CMD_APPEND     = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_INS_POS    = 3'd2,
    CMD_DEL_POS    = 3'd3,
    CMD_INS_AFTER  = 3'd4,
    CMD_INS_BEFORE = 3'd5,
    CMD_READ_FWD   = 3'd6,
    CMD_READ_REV   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  // Operation broadcast to the row of cells.
  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_ROTL = 3'd1,
    OP_ROTR = 3'd2,
    OP_INS  = 3'd3,
    OP_DEL  = 3'd4
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [IDX_W-1:0]      k;
    logic [DATA_WIDTH-1:0] wdata;
  } ctl_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } sts_t;

endpackage

// ===== rtl/dll_cell.sv =====
// ----------------------------------------------------------------------------
// dll_cell
// One list slot: holds a word, takes a neighbor's word on shift or rotate, or the new word on insert.
// ----------------------------------------------------------------------------
module dll_cell
  import dll_pkg::*;
(
  input  logic                  clk,
  input  logic [IDX_W-1:0]      my_idx,
  input  ctl_t                  ctl,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_HOLD: data_nxt = data_r;
      OP_ROTL: data_nxt = right_data;
      OP_ROTR: data_nxt = left_data;
      OP_INS: begin
        if (my_idx > ctl.k) data_nxt = left_data;
        else if (my_idx == ctl.k) data_nxt = ctl.wdata;
      end
      OP_DEL: begin
        if (my_idx >= ctl.k) data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ===== rtl/dll_ctrl.sv =====
// ----------------------------------------------------------------------------
// dll_ctrl
// Command sequencer: decodes a transaction, drives the cell row, and holds
// the result register.
// ----------------------------------------------------------------------------
module dll_ctrl
  import dll_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_command,
  input  logic signed [31:0]    in_value,
  input  logic [POS_W-1:0]      in_position,
  input  logic signed [31:0]    in_target_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic signed [31:0]    out_read_data,
  output logic                  out_last,
  input  logic [DATA_WIDTH-1:0] head_data,
  input  logic [DATA_WIDTH-1:0] end_data,
  output ctl_t                  ctl,
  output sts_t                  sts
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r;
  logic [DATA_WIDTH-1:0] val_r, tgt_r;
  logic [POS_W-1:0]      pos_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      step_r, step_nxt;
  logic [IDX_W-1:0]      match_r, match_nxt;
  logic                  found_r, found_nxt;
  logic                  ovalid_r;
  logic [2:0]            ostat_r;
  logic signed [31:0]    odata_r;
  logic                  olast_r;

  logic                  emit;
  status_t               emit_stat;
  logic signed [31:0]    emit_data;
  logic                  emit_last;
  logic                  ofree;
  logic [CMP_W-1:0]      pos_x, cnt_x, step_x, cap_x;
  logic                  in_list, rev_phase, is_read, is_rev, cap_end;

  assign ofree   = !ovalid_r || !out_stall;
  assign pos_x   = CMP_W'(pos_r);
  assign cnt_x   = CMP_W'(count_r);
  assign step_x  = CMP_W'(step_r);
  assign cap_x   = CMP_W'(CAPACITY);
  assign in_list = step_x < cnt_x;
  assign rev_phase = step_x >= (cap_x - cnt_x);
  assign is_read = (cmd_r == CMD_READ_FWD) || (cmd_r == CMD_READ_REV);
  assign is_rev  = (cmd_r == CMD_READ_REV);
  assign cap_end = step_r == IDX_W'(CAPACITY - 1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    step_nxt  = step_r;
    match_nxt = match_r;
    found_nxt = found_r;
    ctl.op    = OP_HOLD;
    ctl.k     = '0;
    ctl.wdata = val_r;
    emit      = 1'b0;
    emit_stat = ST_OK;
    emit_data = '0;
    emit_last = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (ofree) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          step_nxt  = '0;
          found_nxt = 1'b0;
          case (cmd_r)
            CMD_APPEND: begin
              if (cnt_x == cap_x) emit_stat = ST_FULL;
              else begin
                ctl.op    = OP_INS;
                ctl.k     = IDX_W'(count_r);
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) emit_stat = ST_EMPTY;
              else count_nxt = count_r - 1'b1;
            end
            CMD_INS_POS: begin
              if (pos_r == '0) emit_stat = ST_BADPOS;
              else if (cnt_x == cap_x) emit_stat = ST_FULL;
              else if (pos_x > cnt_x + 1'b1) emit_stat = ST_RANGE;
              else begin
                ctl.op    = OP_INS;
                ctl.k     = IDX_W'(pos_x - 1'b1);
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_DEL_POS: begin
              if (count_r == '0) emit_stat = ST_EMPTY;
              else if (pos_r == '0) emit_stat = ST_BADPOS;
              else if (pos_x > cnt_x) emit_stat = ST_RANGE;
              else begin
                ctl.op    = OP_DEL;
                ctl.k     = IDX_W'(pos_x - 1'b1);
                count_nxt = count_r - 1'b1;
              end
            end
            CMD_INS_AFTER, CMD_INS_BEFORE: begin
              if (count_r == '0) emit_stat = ST_NOTFOUND;
              else begin
                emit      = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              if (count_r == '0) emit_stat = ST_EMPTY;
              else begin
                emit      = 1'b0;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // One full turn of the ring restores the original order.
        if (is_read) begin
          if (is_rev) begin
            if (!rev_phase || ofree) begin
              ctl.op    = OP_ROTR;
              emit      = rev_phase;
              emit_data = 32'(signed'(end_data));
              emit_last = cap_end;
              step_nxt  = step_r + 1'b1;
              if (cap_end) state_nxt = S_IDLE;
            end
          end else begin
            if (!in_list || ofree) begin
              ctl.op    = OP_ROTL;
              emit      = in_list;
              emit_data = 32'(signed'(head_data));
              emit_last = (step_x + 1'b1) == cnt_x;
              step_nxt  = step_r + 1'b1;
              if (cap_end) state_nxt = S_IDLE;
            end
          end
        end else begin
          ctl.op   = OP_ROTL;
          step_nxt = step_r + 1'b1;
          if (in_list && !found_r && head_data == tgt_r) begin
            found_nxt = 1'b1;
            match_nxt = step_r;
          end
          if (cap_end) state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (ofree) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (!found_r) emit_stat = ST_NOTFOUND;
          else if (cnt_x == cap_x) emit_stat = ST_FULL;
          else begin
            ctl.op    = OP_INS;
            ctl.k     = (cmd_r == CMD_INS_AFTER) ? match_r + 1'b1 : match_r;
            count_nxt = count_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
      found_r  <= 1'b0;
      step_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
      step_r  <= step_nxt;
      if (emit) ovalid_r <= 1'b1;
      else if (!out_stall) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= cmd_t'(in_command);
      val_r <= DATA_WIDTH'(in_value);
      tgt_r <= DATA_WIDTH'(in_target_value);
      pos_r <= in_position;
    end
    if (emit) begin
      ostat_r <= emit_stat;
      odata_r <= emit_data;
      olast_r <= emit_last;
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = ovalid_r;
  assign out_status    = ostat_r;
  assign out_read_data = odata_r;
  assign out_last      = olast_r;
  assign sts.idle      = (state_r == S_IDLE);
  assign sts.count     = count_r;

endmodule

// ===== rtl/doubly_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_engine
// Ordered list of signed words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Use: present a command on the in_ channel (valid/stall); it is taken when
// in_valid is high and in_stall low. Results leave on the out_ channel, one
// transaction per status, or one per element for a read-out, with out_last
// on the final one. Element k of the list sits in cell k-1; inserts and
// deletes shift the cells above the spot by one. Append, remove, positional
// insert or delete present their status from the execute state once the
// output register is free, and the engine then returns to idle for the
// next command. Value searches and read-outs turn the whole ring of cells
// once, one cell per cycle: a search presents its status after the full
// turn; a read-out presents one element per cycle unless the receiver
// stalls, which holds the ring, and is ready for the next command when
// the turn ends. One command is worked at a time; a new one is taken while
// the last result still waits in the output register. Reset: the list is
// empty, the output register empty; cell contents are not cleared, since
// only cells below the element count are ever shown. A stall on out_
// freezes the ring while a read-out emits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module doubly_linked_list_engine
  import dll_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_value,
  input  logic [POS_W-1:0]   in_position,
  input  logic signed [31:0] in_target_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_read_data,
  output logic               out_last
);

  ctl_t                  ctl;
  sts_t                  sts;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  dll_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_value        (in_value),
    .in_position     (in_position),
    .in_target_value (in_target_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_read_data   (out_read_data),
    .out_last        (out_last),
    .head_data       (cell_data[0]),
    .end_data        (cell_data[CAPACITY-1]),
    .ctl             (ctl),
    .sts             (sts)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dll_cell u_cell (
      .clk        (clk),
      .my_idx     (IDX_W'(i)),
      .ctl        (ctl),
      .left_data  (cell_data[(i + CAPACITY - 1) % CAPACITY]),
      .right_data (cell_data[(i + 1) % CAPACITY]),
      .data_o     (cell_data[i])
    );
  end

  `DLL_ASSERT(a_count_bound, sts.count <= CNT_W'(CAPACITY), "element count above capacity")
  `DLL_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (sts.count == '0 && !out_valid), "reset not empty")
  `DLL_ASSERT(a_err_last, out_valid && out_status != ST_OK |-> out_last, "error status not last")
  `DLL_ASSERT(a_busy_after_take, in_valid && !in_stall |=> !sts.idle, "idle after accepting")

endmodule

// ===== test/doubly_linked_list_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_tb
// Self-checking bench for the list engine: directed corner commands, then
// random command mixes, checked against a queue-based model of the list.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_tb;
  import dll_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [31:0] data;
    logic        last;
  } result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_command;
  logic signed [31:0] in_value;
  logic [POS_W-1:0]   in_position;
  logic signed [31:0] in_target_value;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic signed [31:0] out_read_data;
  logic               out_last;

  logic [31:0] list_words[$];
  result_t     expected_results[$];
  int          error_count;
  int          command_count;
  int          result_count;
  bit          hold_off_req;
  bit          hold_off_busy;

  doubly_linked_list_engine DUT (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic void predict_list(cmd_t cmd, logic [31:0] val, int pos,
                                       logic [31:0] tgt);
    status_t st;
    int      idx;
    st  = ST_OK;
    idx = -1;
    case (cmd)
      CMD_APPEND:
        if (list_words.size() >= CAPACITY) st = ST_FULL;
        else list_words.push_back(val);
      CMD_REMOVE:
        if (list_words.size() == 0) st = ST_EMPTY;
        else void'(list_words.pop_back());
      CMD_INS_POS:
        if (pos == 0) st = ST_BADPOS;
        else if (list_words.size() >= CAPACITY) st = ST_FULL;
        else if (pos > list_words.size() + 1) st = ST_RANGE;
        else list_words.insert(pos - 1, val);
      CMD_DEL_POS:
        if (list_words.size() == 0) st = ST_EMPTY;
        else if (pos == 0) st = ST_BADPOS;
        else if (pos > list_words.size()) st = ST_RANGE;
        else list_words.delete(pos - 1);
      CMD_INS_AFTER, CMD_INS_BEFORE: begin
        for (int i = 0; i < list_words.size(); i++)
          if (idx < 0 && list_words[i] == tgt) idx = i;
        if (idx < 0) st = ST_NOTFOUND;
        else if (list_words.size() >= CAPACITY) st = ST_FULL;
        else list_words.insert(cmd == CMD_INS_AFTER ? idx + 1 : idx, val);
      end
      default: begin
        if (list_words.size() == 0) begin
          expected_results.push_back('{ST_EMPTY, 32'd0, 1'b1});
        end else begin
          for (int i = 0; i < list_words.size(); i++)
            expected_results.push_back('{ST_OK,
              list_words[cmd == CMD_READ_FWD ? i : list_words.size() - 1 - i],
              i == list_words.size() - 1});
        end
        return;
      end
    endcase
    expected_results.push_back('{st, 32'd0, 1'b1});
  endfunction

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    repeat (n) @(negedge clk);
  endtask

  task automatic send_command(cmd_t cmd, logic [31:0] val, int pos, logic [31:0] tgt,
                              bit gaps = 1'b1);
    if (gaps) random_gap();
    @(negedge clk);
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_value        <= val;
    in_position     <= pos[POS_W-1:0];
    in_target_value <= tgt;
    do @(posedge clk); while (in_stall);
    predict_list(cmd, val, pos, tgt);
    command_count++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (CAPACITY + 8) @(negedge clk);
  endtask

  // Stall the receiver at random, never within a window of commands, or for a long stretch when requested.
  initial begin
    out_stall     = 1'b1;
    hold_off_busy = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_busy = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_off_req  = 1'b0;
        hold_off_busy = 1'b0;
      end else if (command_count > 150 && command_count < 220) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d data=%0h last=%0b", $time,
                 out_status, out_read_data, out_last);
        error_count++;
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (out_status !== e.status || out_read_data !== e.data || out_last !== e.last) begin
          $display("%0t: mismatch expected status=%0d data=%0h last=%0b, actual status=%0d data=%0h last=%0b",
                   $time, e.status, e.data, e.last, out_status, out_read_data, out_last);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_command(CMD_READ_FWD, 0, 0, 0);
    send_command(CMD_READ_REV, 0, 0, 0);
    send_command(CMD_REMOVE, 0, 0, 0);
    send_command(CMD_DEL_POS, 0, 0, 0);
    send_command(CMD_INS_AFTER, 5, 0, 5);
    send_command(CMD_INS_POS, 1, 0, 0);
    send_command(CMD_INS_POS, 32'h7fffffff, 2, 0);
    send_command(CMD_INS_POS, 32'h80000000, 1, 0);
    send_command(CMD_APPEND, 32'hffffffff, 127, 32'hffffffff);
    send_command(CMD_APPEND, 0, 0, 0);
    send_command(CMD_INS_AFTER, 77, 0, 32'h7fffffff);
    send_command(CMD_INS_BEFORE, 88, 0, 32'h80000000);
    send_command(CMD_INS_BEFORE, 99, 0, 32'h12345678);
    send_command(CMD_DEL_POS, 0, 0, 0);
    send_command(CMD_DEL_POS, 0, 127, 0);
    send_command(CMD_DEL_POS, 0, 3, 0);
    send_command(CMD_READ_FWD, 0, 0, 0);
    send_command(CMD_READ_REV, 0, 0, 0);
    send_command(CMD_REMOVE, 0, 0, 0);
    wait_drained();
  endtask

  task automatic test_fill_full();
    while (list_words.size() < CAPACITY)
      send_command(CMD_APPEND, $urandom_range(0, 7), 0, 0, 1'b0);
    send_command(CMD_APPEND, 1, 0, 0);
    send_command(CMD_INS_POS, 1, 0, 0);
    send_command(CMD_INS_POS, 1, 1, 0);
    send_command(CMD_INS_POS, 1, 127, 0);
    send_command(CMD_INS_AFTER, 1, 0, 32'h55555555);
    send_command(CMD_INS_BEFORE, 1, 0, list_words[3]);
    send_command(CMD_READ_FWD, 0, 0, 0);
    send_command(CMD_DEL_POS, 0, CAPACITY, 0);
    send_command(CMD_DEL_POS, 0, 1, 0);
    send_command(CMD_READ_REV, 0, 0, 0);
    while (list_words.size() > 0) send_command(CMD_REMOVE, 0, 0, 0, 1'b0);
    wait_drained();
  endtask

  // Mostly small values so searches hit; full-range words now and then.
  task automatic test_random(int n);
    cmd_t        cmd;
    logic [31:0] v;
    logic [31:0] t;
    int          p;
    int          r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      cmd = CMD_APPEND;
      else if (r < 40) cmd = CMD_REMOVE;
      else if (r < 55) cmd = CMD_INS_POS;
      else if (r < 67) cmd = CMD_DEL_POS;
      else if (r < 77) cmd = CMD_INS_AFTER;
      else if (r < 87) cmd = CMD_INS_BEFORE;
      else if (r < 94) cmd = CMD_READ_FWD;
      else             cmd = CMD_READ_REV;
      v = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 15);
      if (list_words.size() > 0 && $urandom_range(0, 3) != 0)
        t = list_words[$urandom_range(0, list_words.size() - 1)];
      else
        t = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 15);
      p = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                      : $urandom_range(0, list_words.size() + 1);
      send_command(cmd, v, p, t, i % 50 < 40);
    end
  endtask

  task automatic test_backpressure();
    hold_off_req = 1'b1;
    @(negedge clk);
    fork
      test_random(40);
      wait (!hold_off_req && !hold_off_busy);
    join
    wait_drained();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = 3'd0;
    in_value        = '0;
    in_position     = '0;
    in_target_value = '0;
    hold_off_req    = 1'b0;
    error_count     = 0;
    command_count   = 0;
    result_count    = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_fill_full();
    test_random(160);
    test_backpressure();
    test_random(105);
    wait_drained();
    $display("Covered %0d commands and %0d results: every command, status and",
             command_count, result_count);
    $display("  full/empty corner, with random gaps and a long receiver hold-off.");
    if (error_count == 0) begin
      $display("doubly_linked_list_engine_tb: PASS");
    end else begin
      $display("doubly_linked_list_engine_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("doubly_linked_list_engine_tb: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dll_pkg.sv
rtl/dll_cell.sv
rtl/dll_ctrl.sv
rtl/doubly_linked_list_engine.sv
test/doubly_linked_list_engine_tb.sv
